[rtl/suk_pkg.sv]
// Shared types and constants for the sorted unique key table.
// Holds the beat structs, entry and search wave types and the state enum.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package suk_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int KEY_W = 32;
    localparam int VALUE_W = 16;
    localparam int POS_OUT_W = 7;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] part_key;
        logic                    part_kind;
        logic [VALUE_W-1:0]      part_value;
    } in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 found;
        logic [POS_OUT_W-1:0] position;
        logic                 found_kind;
        logic [VALUE_W-1:0]   found_value;
    } out_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] part_key;
        logic                    part_kind;
        logic [VALUE_W-1:0]      part_value;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               gt_seen;
        logic               kind;
        logic [VALUE_W-1:0] value;
    } wave_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/suk_cell.sv]
// One cell of the sorted chain: holds a single entry and one stage of the search wave.
// Shifts its entry towards the next cell on insert. Depends on suk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module suk_cell import suk_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int IDX = 0,
    localparam int POS_W = $clog2(CAPACITY + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire in_t              probe,
    input  wire logic [POS_W-1:0] count,
    input  wire logic             commit,
    input  wire entry_t           left_entry,
    input  wire logic             left_shift,
    input  wire wave_t            left_wave,
    input  wire logic [POS_W-1:0] left_hit_pos,
    input  wire logic [POS_W-1:0] left_slot,
    output entry_t                entry_out,
    output logic                  shift_out,
    output wave_t                 wave_out,
    output logic [POS_W-1:0]      hit_pos_out,
    output logic [POS_W-1:0]      slot_out
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    entry_t           entry_reg;
    wave_t            wave_reg;
    wave_t            wave_next;
    logic [POS_W-1:0] hit_pos_reg;
    logic [POS_W-1:0] hit_pos_next;
    logic [POS_W-1:0] slot_reg;
    logic [POS_W-1:0] slot_next;
    logic             live;
    logic             match;
    logic             gt;
    logic             take;
    entry_t           entry_next;

    assign live  = MY_POS < count;
    assign match = live && (entry_reg.part_key == probe.part_key);
    assign gt    = live && ($signed(entry_reg.part_key) > $signed(probe.part_key));
    assign take  = commit && (gt || (MY_POS == count));

    always_comb begin
        wave_next    = left_wave;
        hit_pos_next = left_hit_pos;
        slot_next    = left_slot;
        if (left_wave.valid && match && !left_wave.hit) begin
            wave_next.hit   = 1'b1;
            wave_next.kind  = entry_reg.part_kind;
            wave_next.value = entry_reg.part_value;
            hit_pos_next    = MY_POS;
        end
        if (left_wave.valid && gt && !left_wave.gt_seen) begin
            wave_next.gt_seen = 1'b1;
            slot_next         = MY_POS;
        end
        if (left_shift) begin
            entry_next = left_entry;
        end else begin
            entry_next.part_key   = probe.part_key;
            entry_next.part_kind  = probe.part_kind;
            entry_next.part_value = probe.part_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg.valid <= 1'b0;
        end else begin
            wave_reg.valid <= wave_next.valid;
        end
        wave_reg.hit     <= wave_next.hit;
        wave_reg.gt_seen <= wave_next.gt_seen;
        wave_reg.kind    <= wave_next.kind;
        wave_reg.value   <= wave_next.value;
        hit_pos_reg      <= hit_pos_next;
        slot_reg         <= slot_next;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out   = entry_reg;
    assign shift_out   = gt;
    assign wave_out    = wave_reg;
    assign hit_pos_out = hit_pos_reg;
    assign slot_out    = slot_reg;

endmodule

`default_nettype wire

[rtl/sorted_unique_key_table.sv]
// Sorted unique key table: a chain of CAPACITY cells kept in ascending signed key order.
// The search wave passes one cell per cycle; the result is registered at the chain end
// and moved to the output register once that is free. A new input beat is taken only
// when idle, after the last result has moved out. The insert shift updates every cell
// of the chain in the same cycle. Reset clears the entry count and control state; entry
// contents are not cleared. Depends on suk_pkg and suk_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_key_table import suk_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int POS_W = $clog2(CAPACITY + 1);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    state_t           state_reg;
    state_t           state_next;
    in_t              probe_reg;
    logic             start_reg;
    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_next;
    out_t             res_reg;
    out_t             res_next;
    logic             ins_ok_reg;
    logic             ins_ok_next;
    logic             m_valid_reg;
    out_t             m_data_reg;
    logic             accept;
    logic             scan_end;
    logic             move_out;
    logic             commit;
    logic [POS_W-1:0] pos_sel;
    logic [POS_W+POS_OUT_W-1:0] pos_ext;

    entry_t           entry_chain [CAPACITY+1];
    logic             shift_chain [CAPACITY+1];
    wave_t            wave_chain [CAPACITY+1];
    logic [POS_W-1:0] hit_pos_chain [CAPACITY+1];
    logic [POS_W-1:0] slot_chain [CAPACITY+1];

    assign entry_chain[0]   = '0;
    assign shift_chain[0]   = 1'b0;
    assign hit_pos_chain[0] = '0;
    assign slot_chain[0]    = '0;
    always_comb begin
        wave_chain[0]       = '0;
        wave_chain[0].valid = start_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        suk_cell #(
            .CAPACITY(CAPACITY),
            .IDX     (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .probe       (probe_reg),
            .count       (count_reg),
            .commit      (commit),
            .left_entry  (entry_chain[i]),
            .left_shift  (shift_chain[i]),
            .left_wave   (wave_chain[i]),
            .left_hit_pos(hit_pos_chain[i]),
            .left_slot   (slot_chain[i]),
            .entry_out   (entry_chain[i+1]),
            .shift_out   (shift_chain[i+1]),
            .wave_out    (wave_chain[i+1]),
            .hit_pos_out (hit_pos_chain[i+1]),
            .slot_out    (slot_chain[i+1])
        );
    end

    assign scan_end = wave_chain[CAPACITY].valid;

    always_comb begin
        res_next    = '0;
        ins_ok_next = 1'b0;
        pos_sel     = count_reg;
        if (probe_reg.action == ACT_LOOKUP) begin
            if (wave_chain[CAPACITY].hit) begin
                res_next.found       = 1'b1;
                res_next.found_kind  = wave_chain[CAPACITY].kind;
                res_next.found_value = wave_chain[CAPACITY].value;
                pos_sel              = hit_pos_chain[CAPACITY];
            end
        end else if (wave_chain[CAPACITY].hit) begin
            res_next.status = ST_DUP;
            res_next.found  = 1'b1;
            pos_sel         = hit_pos_chain[CAPACITY];
        end else if (count_reg >= CAP_POS) begin
            res_next.status = ST_FULL;
        end else begin
            ins_ok_next = 1'b1;
            if (wave_chain[CAPACITY].gt_seen) begin
                pos_sel = slot_chain[CAPACITY];
            end
        end
        pos_ext           = {{POS_OUT_W{1'b0}}, pos_sel};
        res_next.position = pos_ext[POS_OUT_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        move_out   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    move_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept     = s_valid && s_ready;
    assign commit     = move_out && ins_ok_reg;
    assign count_next = commit ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            ins_ok_reg  <= 1'b0;
        end else begin
            start_reg <= accept;
            count_reg <= count_next;
            if (scan_end && state_reg == S_SCAN) begin
                ins_ok_reg <= ins_ok_next;
            end
            if (move_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            probe_reg <= s_data;
        end
        if (scan_end && state_reg == S_SCAN) begin
            res_reg <= res_next;
        end
        if (move_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_POS)
        else $error("Entry count exceeds capacity.");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Successful insert did not advance the entry count.");

    a_wave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !scan_end && !start_reg)
        else $error("Search wave still in flight while a new beat is accepted.");
`endif

endmodule

`default_nettype wire

[tb/sorted_unique_key_table_tb.sv]
// Self-checking testbench for the sorted unique key table: inserts and lookups go in as beats,
// and every result beat is checked against a behavioural table model kept in the testbench.
// Depends on suk_pkg and sorted_unique_key_table.
`timescale 1ns / 1ps

module sorted_unique_key_table_tb;
    import suk_pkg::*;

    localparam int TABLE_DEPTH = CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS = 1480;
    localparam int TAIL_ITEMS = 100;

    typedef struct {
        in_t beat;
        bit  drain_first;
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    request_t                request_queue[$];
    out_t                    outcome_queue[$];
    logic signed [KEY_W-1:0] key_pool[$];

    logic signed [KEY_W-1:0] shadow_key[TABLE_DEPTH];
    logic                    shadow_kind[TABLE_DEPTH];
    logic [VALUE_W-1:0]      shadow_value[TABLE_DEPTH];
    int                      shadow_count;

    int unsigned mismatches = 0;
    int unsigned beats_sent;
    int unsigned gap_left;
    int unsigned stall_left;
    logic        idling_on = 1'b0;

    sorted_unique_key_table #(
        .CAPACITY(TABLE_DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic out_t table_outcome(in_t req);
        out_t res;
        int   hit_at;
        int   slot;
        int   i;
        res = '0;
        res.status = ST_OK;
        hit_at = -1;
        for (i = 0; i < shadow_count; i++) begin
            if (hit_at < 0 && shadow_key[i] == req.part_key) begin
                hit_at = i;
            end
        end
        if (hit_at >= 0) begin
            res.found = 1'b1;
            res.position = POS_OUT_W'(hit_at);
            if (req.action == ACT_LOOKUP) begin
                res.found_kind = shadow_kind[hit_at];
                res.found_value = shadow_value[hit_at];
            end else begin
                res.status = ST_DUP;
            end
        end else if (req.action == ACT_LOOKUP) begin
            res.position = POS_OUT_W'(shadow_count);
        end else if (shadow_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
            res.position = POS_OUT_W'(shadow_count);
        end else begin
            slot = 0;
            while (slot < shadow_count && $signed(shadow_key[slot]) <= $signed(req.part_key)) begin
                slot++;
            end
            for (i = shadow_count; i > slot; i--) begin
                shadow_key[i] = shadow_key[i-1];
                shadow_kind[i] = shadow_kind[i-1];
                shadow_value[i] = shadow_value[i-1];
            end
            shadow_key[slot] = req.part_key;
            shadow_kind[slot] = req.part_kind;
            shadow_value[slot] = req.part_value;
            shadow_count++;
            res.position = POS_OUT_W'(slot);
        end
        return res;
    endfunction

    function automatic bit pool_has(logic signed [KEY_W-1:0] key);
        foreach (key_pool[i]) begin
            if (key_pool[i] == key) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic signed [KEY_W-1:0] fresh_key();
        logic signed [KEY_W-1:0] k;
        do begin
            case ($urandom_range(0, 3))
                0: k = $urandom_range(0, 64) - 32;
                1: k = 32'h8000_0000 + $urandom_range(0, 15);
                2: k = 32'h7FFF_FFFF - $urandom_range(0, 15);
                default: k = $urandom;
            endcase
        end while (pool_has(k));
        return k;
    endfunction

    function automatic logic signed [KEY_W-1:0] pool_pick();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    task automatic add_request(logic act, logic signed [KEY_W-1:0] key, logic kind,
                               logic [VALUE_W-1:0] value, bit drain);
        request_t r;
        r.beat.action = act;
        r.beat.part_key = key;
        r.beat.part_kind = kind;
        r.beat.part_value = value;
        r.drain_first = drain;
        request_queue.push_back(r);
        if (act == ACT_INSERT && !pool_has(key) && key_pool.size() < TABLE_DEPTH) begin
            key_pool.push_back(key);
        end
    endtask

    task automatic check_field(string name, int unsigned expected, int unsigned actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        request_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            shadow_count = 0;
            beats_sent = 0;
            gap_left = 0;
            idling_on <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                outcome_queue.push_back(table_outcome(s_data));
                beats_sent++;
            end
            idling_on <= request_queue.size() > TAIL_ITEMS && (beats_sent / 128) % 4 != 3;
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_queue.size() == 0 ||
                             (request_queue[0].drain_first && outcome_queue.size() != 0)) begin
                    s_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else begin
                    next_req = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data <= next_req.beat;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_queue.size() == 0) begin
                    $error("result beat arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = outcome_queue.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("found", want.found, m_data.found);
                    check_field("position", want.position, m_data.position);
                    check_field("found_kind", want.found_kind, m_data.found_kind);
                    check_field("found_value", want.found_value, m_data.found_value);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned pick;
        logic signed [KEY_W-1:0] k;

        // Directed opening: empty table, extreme keys, ordering and duplicates.
        add_request(ACT_LOOKUP, 32'sd0, 1'b0, 16'h0000, 1'b0);
        add_request(ACT_INSERT, 32'sd0, 1'b0, 16'h0000, 1'b0);
        add_request(ACT_INSERT, 32'sd0, 1'b1, 16'hFFFF, 1'b0);
        add_request(ACT_INSERT, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
        add_request(ACT_INSERT, 32'h8000_0000, 1'b1, 16'h1234, 1'b0);
        add_request(ACT_INSERT, -32'sd1, 1'b0, 16'h8000, 1'b0);
        add_request(ACT_INSERT, 32'sd1, 1'b1, 16'h0001, 1'b0);
        add_request(ACT_LOOKUP, 32'h8000_0000, 1'b0, 16'h0000, 1'b0);
        add_request(ACT_LOOKUP, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
        add_request(ACT_LOOKUP, -32'sd1, 1'b0, 16'h0000, 1'b0);
        add_request(ACT_LOOKUP, 32'sd2, 1'b0, 16'h0000, 1'b0);
        add_request(ACT_LOOKUP, 32'h8000_0001, 1'b1, 16'hFFFF, 1'b0);
        add_request(ACT_INSERT, 32'h7FFF_FFFF, 1'b0, 16'h5A5A, 1'b0);
        add_request(ACT_LOOKUP, 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0);
        add_request(ACT_INSERT, 32'h7FFF_FFFE, 1'b0, 16'hA5A5, 1'b0);
        add_request(ACT_LOOKUP, 32'sd0, 1'b1, 16'h0000, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                k = fresh_key();
                add_request(ACT_INSERT, k, 1'($urandom), VALUE_W'($urandom),
                            n == 0 || n == RANDOM_ITEMS / 2);
            end else if (pick < 20) begin
                add_request(ACT_INSERT, pool_pick(), 1'($urandom), VALUE_W'($urandom),
                            n == 0 || n == RANDOM_ITEMS / 2);
            end else if (pick < 60) begin
                add_request(ACT_LOOKUP, pool_pick(), 1'($urandom), VALUE_W'($urandom),
                            n == 0 || n == RANDOM_ITEMS / 2);
            end else if (pick < 80) begin
                k = pool_pick() + ($urandom_range(0, 1) ? 1 : -1);
                add_request(ACT_LOOKUP, k, 1'($urandom), VALUE_W'($urandom),
                            n == 0 || n == RANDOM_ITEMS / 2);
            end else begin
                add_request(ACT_LOOKUP, fresh_key(), 1'($urandom), VALUE_W'($urandom),
                            n == 0 || n == RANDOM_ITEMS / 2);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (request_queue.size() != 0 || s_valid || outcome_queue.size() != 0);
        repeat (2 * TABLE_DEPTH + 8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("sorted_unique_key_table_tb passed");
        end else begin
            $display("sorted_unique_key_table_tb failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sorted_unique_key_table_tb failed");
        $finish;
    end

endmodule
